[rtl/core/md5_message_digest_top_defines.svh]
`ifndef MD5_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_TOP_DEFINES_SVH

// same-cycle implication
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/md5_pkg.sv]
package md5_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} dig_t;

	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [5:0] t;
		t = 6'd0;
		case (i[5:4])
			2'd0: t = i;
			2'd1: t = (i << 2) + i + 6'd1;
			2'd2: t = (i << 1) + i + 6'd5;
			default: t = (i << 3) - i;
		endcase
		return t[3:0];
	endfunction

	function automatic logic [4:0] rot_amount(input logic [3:0] k);
		logic [4:0] s;
		s = 5'd0;
		case (k)
			4'd0: s = 5'd7;
			4'd1: s = 5'd12;
			4'd2: s = 5'd17;
			4'd3: s = 5'd22;
			4'd4: s = 5'd5;
			4'd5: s = 5'd9;
			4'd6: s = 5'd14;
			4'd7: s = 5'd20;
			4'd8: s = 5'd4;
			4'd9: s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

	function automatic logic [31:0] sine_const(input logic [5:0] i);
		logic [31:0] k;
		k = 32'd0;
		case (i)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/md5_message_digest_top.sv]
// Request bytes are taken one per cycle while idle; every 64th byte starts a compression
// (a prefetch step, 64 rounds at one per cycle, one chaining add) that stalls requests.
// End of message: up to 16 padding word writes and one compression (two when the
// length does not fit), then four digest words, one per cycle while not stalled.
// Throughput is set by the single-round datapath and the single-write-port block buffer.
// Reset clears control, chaining words and byte count; the block buffer is not cleared.
`include "md5_message_digest_top_defines.svh"

module md5_message_digest_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  md5_pkg::req_t req,
	output logic          dig_valid,
	input  logic          dig_stall,
	output md5_pkg::dig_t dig
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PAD  = 6'b000010,
		ST_PRE  = 6'b000100,
		ST_RND  = 6'b001000,
		ST_FIN  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_MSG  = 2'd0,
		PH_PAD1 = 2'd1,
		PH_PAD2 = 2'd2
	} phase_t;

	localparam logic [3:0] LEN_LO_IDX = 4'd14;
	localparam logic [3:0] LEN_HI_IDX = 4'd15;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LAST_RND   = 6'd63;
	localparam logic [1:0] LAST_WORD  = 2'd3;

	state_t      state_q;
	phase_t      phase_q;
	logic        fin_q;
	logic [63:0] count_q;
	logic [31:0] acc_q;
	logic [3:0]  pw_q;
	logic [5:0]  rnd_q;
	logic [1:0]  oi_q;
	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;

	logic [31:0] buf_mem [16];
	logic [31:0] rd_q;

	logic        acc_en;
	logic [5:0]  pos;
	logic [63:0] count_nxt;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;
	logic [3:0]  rd_addr;
	logic        len_blk;
	logic        overflow;
	logic [31:0] part_word;
	logic [31:0] pad_word;
	logic [31:0] f_val;
	logic [31:0] sum;
	logic [31:0] new_b;
	logic        dig_acc;

	assign req_stall = (state_q != ST_IDLE);
	assign acc_en    = req_valid && (state_q == ST_IDLE);
	assign pos       = count_q[5:0];
	assign count_nxt = count_q + {63'd0, req.has_byte};
	assign overflow  = (count_q[5:3] == 3'b111);
	assign len_blk   = (phase_q == PH_PAD2) || !overflow;
	assign dig_valid = (state_q == ST_OUT);
	assign dig_acc   = dig_valid && !dig_stall;

	assign dig.digest_word = chain_q[oi_q];
	assign dig.word_index  = oi_q;
	assign dig.last_word   = (oi_q == LAST_WORD);

	always_comb begin
		part_word = 32'd0;
		case (count_q[1:0])
			2'd0: part_word = {24'd0, md5_pkg::PAD_BYTE};
			2'd1: part_word = {16'd0, md5_pkg::PAD_BYTE, acc_q[7:0]};
			2'd2: part_word = {8'd0, md5_pkg::PAD_BYTE, acc_q[15:0]};
			default: part_word = {md5_pkg::PAD_BYTE, acc_q[23:0]};
		endcase
	end

	always_comb begin
		if (phase_q == PH_PAD1 && pw_q == count_q[5:2]) begin
			pad_word = part_word;
		end else if (len_blk && pw_q == LEN_LO_IDX) begin
			pad_word = {count_q[28:0], 3'b000};
		end else if (len_blk && pw_q == LEN_HI_IDX) begin
			pad_word = count_q[60:29];
		end else begin
			pad_word = 32'd0;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pw_q;
		wr_data = pad_word;
		if (state_q == ST_PAD) begin
			wr_en = 1'b1;
		end else if (acc_en && req.has_byte && pos[1:0] == 2'd3) begin
			wr_en   = 1'b1;
			wr_addr = pos[5:2];
			wr_data = {req.data_byte, acc_q[23:0]};
		end
	end

	always_comb begin
		if (state_q == ST_RND) begin
			rd_addr = md5_pkg::msg_index(rnd_q + 6'd1);
		end else begin
			rd_addr = md5_pkg::msg_index(6'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= wr_data;
		end
		rd_q <= buf_mem[rd_addr];
	end

	always_comb begin
		f_val = 32'd0;
		case (rnd_q[5:4])
			2'd0: f_val = (b_q & c_q) | (~b_q & d_q);
			2'd1: f_val = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f_val = b_q ^ c_q ^ d_q;
			default: f_val = c_q ^ (b_q | ~d_q);
		endcase
		sum   = a_q + f_val + md5_pkg::sine_const(rnd_q) + rd_q;
		new_b = b_q + md5_pkg::rotl32(sum, md5_pkg::rot_amount({rnd_q[5:4], rnd_q[1:0]}));
	end

	always_ff @(posedge clk) begin
		if (acc_en && req.has_byte) begin
			if (pos[1:0] == 2'd0) begin
				acc_q <= {24'd0, req.data_byte};
			end else begin
				acc_q[{pos[1:0], 3'b000} +: 8] <= req.data_byte;
			end
		end
		case (state_q)
			ST_PRE: begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
			end
			ST_RND: begin
				a_q <= d_q;
				b_q <= new_b;
				c_q <= b_q;
				d_q <= c_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_MSG;
			fin_q      <= 1'b0;
			count_q    <= 64'd0;
			pw_q       <= 4'd0;
			rnd_q      <= 6'd0;
			oi_q       <= 2'd0;
			chain_q[0] <= md5_pkg::IV_A;
			chain_q[1] <= md5_pkg::IV_B;
			chain_q[2] <= md5_pkg::IV_C;
			chain_q[3] <= md5_pkg::IV_D;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_en) begin
						count_q <= count_nxt;
						fin_q   <= req.end_of_message;
						if (req.has_byte && pos == LAST_POS) begin
							phase_q <= PH_MSG;
							state_q <= ST_PRE;
						end else if (req.end_of_message) begin
							phase_q <= PH_PAD1;
							pw_q    <= count_nxt[5:2];
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pw_q <= pw_q + 4'd1;
					if (pw_q == LEN_HI_IDX) begin
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					rnd_q   <= 6'd0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == LAST_RND) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					if (phase_q == PH_MSG && !fin_q) begin
						state_q <= ST_IDLE;
					end else if (phase_q == PH_MSG) begin
						phase_q <= PH_PAD1;
						pw_q    <= count_q[5:2];
						state_q <= ST_PAD;
					end else if (phase_q == PH_PAD1 && overflow) begin
						phase_q <= PH_PAD2;
						pw_q    <= 4'd0;
						state_q <= ST_PAD;
					end else begin
						oi_q    <= 2'd0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						oi_q <= oi_q + 2'd1;
						if (oi_q == LAST_WORD) begin
							chain_q[0] <= md5_pkg::IV_A;
							chain_q[1] <= md5_pkg::IV_B;
							chain_q[2] <= md5_pkg::IV_C;
							chain_q[3] <= md5_pkg::IV_D;
							count_q    <= 64'd0;
							fin_q      <= 1'b0;
							phase_q    <= PH_MSG;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MD5_ASSERT_NOW(a_wr_state, wr_en, state_q == ST_IDLE || state_q == ST_PAD, "buffer write outside fill or padding")
	`MD5_ASSERT_NEXT(a_rnd_end, state_q == ST_RND && rnd_q == LAST_RND, state_q == ST_FIN, "round count overrun")
	`MD5_ASSERT_NEXT(a_msg_done, dig_acc && dig.last_word, state_q == ST_IDLE && count_q == 64'd0, "message state not cleared after digest")
	`MD5_ASSERT_NOW(a_out_stall, dig_valid, req_stall, "request taken while digest pending")

endmodule
